[sv/adef_pkg.sv]
// Shared types and constants for the archive directory endian fixer.
`timescale 1ns / 1ps

package adef_pkg;

    localparam int unsigned ENTRY_SHIFT = 6;

    localparam logic [31:0] HDR_BYTES   = 32'h0000_0010;
    localparam logic [31:0] GROUP_LIMIT = 32'h0004_0000;
    localparam logic [31:0] WORD_STEP   = 32'h0000_0004;
    localparam logic [31:0] GROUP_HDR_BYTES = 32'h0000_0008;

    localparam logic [ENTRY_SHIFT-1:0] WORD_FIELD_MIN = 6'h04;
    localparam logic [ENTRY_SHIFT-1:0] WORD_FIELD_MAX = 6'h0C;
    localparam logic [ENTRY_SHIFT-1:0] LAST_FIELD     = 6'h3C;

    typedef enum logic [1:0] {
        CONV_PASS        = 2'd0,
        CONV_SWAP32      = 2'd1,
        CONV_SWAP16_BOTH = 2'd2,
        CONV_SWAP16_HIGH = 2'd3
    } conv_t;

    typedef enum logic [1:0] {
        PH_GROUP_HDR    = 2'd0,
        PH_GROUP_SECOND = 2'd1,
        PH_ENTRIES      = 2'd2
    } phase_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic        start_of_file;
    } word_item_t;

    typedef struct packed {
        logic [31:0] out_word;
        conv_t       conversion;
        logic        fault;
    } result_item_t;

    typedef struct packed {
        conv_t conversion;
        logic  fault;
    } parse_result_t;

endpackage

[sv/adef_parser.sv]
// Directory parser: tracks file position and structure, picks each word's conversion.
`timescale 1ns / 1ps

module adef_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [31:0]            data_word,
    input  logic                   start_of_file,
    output adef_pkg::parse_result_t result
);

    logic [31:0]      pos_reg, pos_next;
    logic [31:0]      dir_end_reg, dir_end_next;
    logic [31:0]      group_total_reg, group_total_next;
    logic [31:0]      group_number_reg, group_number_next;
    logic [31:0]      next_start_reg, next_start_next;
    logic [31:0]      group_base_reg, group_base_next;
    logic [31:0]      rec_limit_reg, rec_limit_next;
    adef_pkg::phase_t phase_reg, phase_next;
    logic             active_reg, active_next;
    logic             fault_reg, fault_next;

    logic [31:0]      cur_pos;
    logic [31:0]      cur_dir_end;
    logic [31:0]      cur_group_total;
    logic [31:0]      cur_group_number;
    logic [31:0]      cur_next_start;
    logic [31:0]      cur_group_base;
    logic [31:0]      cur_rec_limit;
    adef_pkg::phase_t cur_phase;
    logic             cur_fault;
    logic             cur_active;

    logic                              in_header;
    logic                              group_hit;
    logic                              hdr_overrun;
    logic [38:0]                       rec_end;
    logic                              bad_group;
    logic                              last_word;
    logic [31:0]                       rel_full;
    logic [adef_pkg::ENTRY_SHIFT-1:0]  rel;
    logic                              group_done;
    logic [31:0]                       group_number_inc;

    // A start mark restarts the parse from the reset values of the state, with the parser made active.
    assign cur_pos          = start_of_file ? 32'h0 : pos_reg;
    assign cur_dir_end      = start_of_file ? 32'h0 : dir_end_reg;
    assign cur_group_total  = start_of_file ? 32'h0 : group_total_reg;
    assign cur_group_number = start_of_file ? 32'h0 : group_number_reg;
    assign cur_next_start   = start_of_file ? adef_pkg::HDR_BYTES : next_start_reg;
    assign cur_group_base   = start_of_file ? 32'h0 : group_base_reg;
    assign cur_rec_limit    = start_of_file ? 32'h0 : rec_limit_reg;
    assign cur_phase        = start_of_file ? adef_pkg::PH_GROUP_HDR : phase_reg;
    assign cur_fault        = start_of_file ? 1'b0 : fault_reg;
    assign cur_active       = start_of_file ? 1'b1 : ((pos_reg == 32'h0) ? 1'b0 : active_reg);

    assign in_header   = (cur_pos[31:4] == 28'h0);
    assign group_hit   = (cur_pos == cur_next_start);
    assign hdr_overrun = ({1'b0, cur_pos} + {1'b0, adef_pkg::GROUP_HDR_BYTES})
                         > {1'b0, cur_dir_end};
    assign rec_end     = {7'h0, cur_pos} + {7'h0, adef_pkg::GROUP_HDR_BYTES}
                         + ({7'h0, data_word} << adef_pkg::ENTRY_SHIFT);
    assign bad_group   = (data_word > adef_pkg::GROUP_LIMIT)
                         || (rec_end > {7'h0, cur_dir_end});
    assign last_word   = ((cur_pos + adef_pkg::WORD_STEP) == cur_rec_limit);
    assign rel_full    = cur_pos - cur_group_base - adef_pkg::GROUP_HDR_BYTES;
    assign rel         = rel_full[adef_pkg::ENTRY_SHIFT-1:0];
    assign group_number_inc = cur_group_number + 32'h1;

    always_comb
    begin
        pos_next          = cur_pos + adef_pkg::WORD_STEP;
        dir_end_next      = cur_dir_end;
        group_total_next  = cur_group_total;
        group_number_next = cur_group_number;
        next_start_next   = cur_next_start;
        group_base_next   = cur_group_base;
        rec_limit_next    = cur_rec_limit;
        phase_next        = cur_phase;
        active_next       = cur_active;
        fault_next        = cur_fault;
        group_done        = 1'b0;

        if (cur_active)
        begin
            if (in_header)
            begin
                if (cur_pos == 32'h0)
                begin
                    dir_end_next = data_word + adef_pkg::HDR_BYTES;
                end
                else if (cur_pos == 32'h8)
                begin
                    group_total_next = data_word;
                end
            end
            else
            begin
                unique case (cur_phase)
                    adef_pkg::PH_GROUP_HDR:
                    begin
                        if (group_hit)
                        begin
                            if (hdr_overrun)
                            begin
                                active_next = 1'b0;
                            end
                            else
                            begin
                                group_base_next = cur_pos;
                                rec_limit_next  = rec_end[31:0];
                                phase_next      = adef_pkg::PH_GROUP_SECOND;
                                if (bad_group)
                                begin
                                    fault_next = 1'b1;
                                end
                            end
                        end
                    end
                    adef_pkg::PH_GROUP_SECOND:
                    begin
                        if (cur_fault)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = adef_pkg::PH_ENTRIES;
                            group_done = last_word;
                        end
                    end
                    adef_pkg::PH_ENTRIES:
                    begin
                        group_done = last_word;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (group_done)
            begin
                group_number_next = group_number_inc;
                next_start_next   = cur_rec_limit;
                phase_next        = adef_pkg::PH_GROUP_HDR;
                if ((group_number_inc >= cur_group_total) || (cur_rec_limit >= cur_dir_end))
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        result.conversion = adef_pkg::CONV_PASS;
        result.fault      = fault_next;
        if (cur_active)
        begin
            if (in_header)
            begin
                result.conversion = adef_pkg::CONV_SWAP32;
            end
            else
            begin
                unique case (cur_phase)
                    adef_pkg::PH_GROUP_HDR:
                    begin
                        if (group_hit && !hdr_overrun)
                        begin
                            result.conversion = adef_pkg::CONV_SWAP32;
                        end
                    end
                    adef_pkg::PH_GROUP_SECOND:
                    begin
                        result.conversion = adef_pkg::CONV_SWAP32;
                    end
                    adef_pkg::PH_ENTRIES:
                    begin
                        if ((rel >= adef_pkg::WORD_FIELD_MIN) && (rel <= adef_pkg::WORD_FIELD_MAX))
                        begin
                            result.conversion = adef_pkg::CONV_SWAP32;
                        end
                        else if (rel == adef_pkg::LAST_FIELD)
                        begin
                            result.conversion = adef_pkg::CONV_SWAP16_HIGH;
                        end
                        else
                        begin
                            result.conversion = adef_pkg::CONV_SWAP16_BOTH;
                        end
                    end
                    default:
                    begin
                        result.conversion = adef_pkg::CONV_PASS;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= 32'h0;
            dir_end_reg      <= 32'h0;
            group_total_reg  <= 32'h0;
            group_number_reg <= 32'h0;
            next_start_reg   <= adef_pkg::HDR_BYTES;
            group_base_reg   <= 32'h0;
            rec_limit_reg    <= 32'h0;
            phase_reg        <= adef_pkg::PH_GROUP_HDR;
            active_reg       <= 1'b0;
            fault_reg        <= 1'b0;
        end
        else if (step)
        begin
            pos_reg          <= pos_next;
            dir_end_reg      <= dir_end_next;
            group_total_reg  <= group_total_next;
            group_number_reg <= group_number_next;
            next_start_reg   <= next_start_next;
            group_base_reg   <= group_base_next;
            rec_limit_reg    <= rec_limit_next;
            phase_reg        <= phase_next;
            active_reg       <= active_next;
            fault_reg        <= fault_next;
        end
    end

endmodule

[sv/adef_swap.sv]
// Byte swapper that applies the selected conversion to one word.
`timescale 1ns / 1ps

module adef_swap (
    input  logic [31:0]     data_word,
    input  adef_pkg::conv_t conversion,
    output logic [31:0]     out_word
);

    always_comb
    begin
        unique case (conversion)
            adef_pkg::CONV_PASS:
                out_word = data_word;
            adef_pkg::CONV_SWAP32:
                out_word = {data_word[7:0], data_word[15:8], data_word[23:16], data_word[31:24]};
            adef_pkg::CONV_SWAP16_BOTH:
                out_word = {data_word[23:16], data_word[31:24], data_word[7:0], data_word[15:8]};
            adef_pkg::CONV_SWAP16_HIGH:
                out_word = {data_word[23:16], data_word[31:24], data_word[15:0]};
            default:
                out_word = data_word;
        endcase
    end

endmodule

[sv/archive_directory_endian_fixer_core.sv]
// Top level of the archive directory endian fixer: input register, parser, swapper, result register.
`timescale 1ns / 1ps

// The block takes a sound-archive file as 4-byte words in file order on the word
// channel and returns each word, byte order corrected, on the result channel.
// A word transfer carries data_word and start_of_file; start_of_file marks file
// offset zero and restarts the parse. Each word gives exactly one result, which
// carries the converted word, the conversion applied and the fault flag.
// A transferred word lands in the input register; the parser and swapper, which
// are plain combinational logic, fill the result register when it can advance.
// Throughput is one word per cycle while the receiver does not stall, set by the
// single parser state update per word, and one further word can be taken while
// a result waits to be taken. When the receiver stalls, the result register
// holds its payload and the input register holds the next word; word_stall rises
// only when both are full. Reset empties both registers and returns the parser
// to its idle state, in which words pass unchanged until a start of file is seen.

module archive_directory_endian_fixer_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   word_valid,
    output logic                   word_stall,
    input  adef_pkg::word_item_t   word_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output adef_pkg::result_item_t result_item
);

    logic                   s1_valid_reg;
    adef_pkg::word_item_t   s1_item_reg;
    logic                   s2_valid_reg;
    adef_pkg::result_item_t s2_item_reg;

    logic                    advance;
    logic                    load_s1;
    adef_pkg::parse_result_t parse_result;
    logic [31:0]             swapped;
    adef_pkg::result_item_t  result_next;

    assign advance    = !s2_valid_reg || !result_stall;
    assign word_stall = s1_valid_reg && !advance;
    assign load_s1    = !s1_valid_reg || advance;

    adef_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_valid_reg && advance),
        .data_word     (s1_item_reg.data_word),
        .start_of_file (s1_item_reg.start_of_file),
        .result        (parse_result)
    );

    adef_swap u_swap (
        .data_word  (s1_item_reg.data_word),
        .conversion (parse_result.conversion),
        .out_word   (swapped)
    );

    always_comb
    begin
        result_next.out_word   = swapped;
        result_next.conversion = parse_result.conversion;
        result_next.fault      = parse_result.fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s1)
            begin
                s1_valid_reg <= word_valid;
            end
            if (advance)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1 && word_valid)
        begin
            s1_item_reg <= word_item;
        end
        if (advance && s1_valid_reg)
        begin
            s2_item_reg <= result_next;
        end
    end

    assign result_valid = s2_valid_reg;
    assign result_item  = s2_item_reg;

endmodule

[sv/adef_checker.sv]
// Port-level checker for the archive directory endian fixer, bound to the top level.
`timescale 1ns / 1ps

module adef_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   word_valid,
    input logic                   word_stall,
    input logic                   result_valid,
    input logic                   result_stall,
    input adef_pkg::result_item_t result_item
);

    a_result_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("Result valid dropped while stalled.");

    a_result_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_item))
        else $error("Result payload changed while stalled.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        word_stall |-> result_valid && result_stall)
        else $error("Word channel stalled while the result side could move.");

    a_result_follows_word: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_stall |=> ##1 result_valid)
        else $error("No result offered two cycles after a word transfer.");

endmodule

bind archive_directory_endian_fixer_core adef_checker u_adef_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);
